@@ rtl/tgse_pkg.sv @@
// ----------------------------------------------------------------------------
// tgse_pkg
// Shared types and constants of the text grid scroll and erase engine.
// ----------------------------------------------------------------------------
package tgse_pkg;

    typedef enum logic [2:0] {
        OP_INIT       = 3'd0,
        OP_SCROLL_UP  = 3'd1,
        OP_SCROLL_DN  = 3'd2,
        OP_ERASE      = 3'd3,
        OP_WRITE      = 3'd4,
        OP_READ       = 3'd5,
        OP_SET_ATTR   = 3'd6,
        OP_RESET_ATTR = 3'd7
    } t_opcode;

    localparam logic [1:0] CFG_COLS    = 2'd0;
    localparam logic [1:0] CFG_ROWS    = 2'd1;
    localparam logic [1:0] CFG_MARGIN  = 2'd2;
    localparam logic [1:0] CFG_DEFATTR = 2'd3;

    localparam logic [1:0] ERASE_TO_END   = 2'd0;
    localparam logic [1:0] ERASE_TO_CURS  = 2'd1;
    localparam logic [1:0] ERASE_ALL      = 2'd2;

    localparam logic [7:0] BLANK_CHAR = 8'h20;
    localparam logic [7:0] RESET_ATTR = 8'h07;

    // controller to datapath
    typedef struct packed {
        logic latch;      // capture the command
        logic map_id;     // load identity map
        logic map_rot;    // rotate map by one step
        logic attr_def;   // current attribute <- default
        logic attr_set;   // current attribute <- command value
        logic fill_start; // load fill bounds for the planned job
        logic fill_step;  // write one blank cell, advance
        logic cell_wr;    // write one cell
        logic clr_step;   // write one reset cell, advance
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic on_screen;  // command cell on screen
        logic fill_last;  // current blank cell is the last one
        logic fill_empty; // planned fill has no cell
        logic rot_last;   // rotation step count done
        logic scroll_ok;  // start row within margin, count nonzero
        logic scroll_all; // count covers region
        logic clr_last;   // last cell of the reset pass
    } t_sts;

endpackage

@@ rtl/tgse_ram.sv @@
// ----------------------------------------------------------------------------
// tgse_ram
// Single port RAM with registered read.
// ----------------------------------------------------------------------------
module tgse_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

@@ rtl/tgse_datapath.sv @@
// ----------------------------------------------------------------------------
// tgse_datapath
// Command registers, row map, blank fill sweep and cell store access.
// ----------------------------------------------------------------------------
module tgse_datapath #(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tgse_pkg::t_cmd  i_cmd,
    output tgse_pkg::t_sts  o_sts,
    input  logic [7:0]      i_cols,
    input  logic [5:0]      i_rows,
    input  logic [4:0]      i_margin,
    input  logic [7:0]      i_defattr,
    input  logic [2:0]      i_opcode,
    input  logic [4:0]      i_row,
    input  logic [6:0]      i_col,
    input  logic [5:0]      i_count,
    input  logic [1:0]      i_erase_mode,
    input  logic [7:0]      i_char_code,
    input  logic [7:0]      i_attr_value,
    output logic [15:0]     o_rdata
);
    localparam int CW = $clog2(MAX_COLS);
    localparam int RW = $clog2(MAX_ROWS);
    localparam int CL = $clog2(MAX_COLS + 1);
    localparam int RL = $clog2(MAX_ROWS + 1);
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW = $clog2(DEPTH);

    logic [2:0] r_op;
    logic [4:0] r_row;
    logic [6:0] r_col;
    logic [5:0] r_count;
    logic [1:0] r_mode;
    logic [7:0] r_char;
    logic [7:0] r_attr;
    logic [7:0] r_cur_attr;
    logic [RW-1:0] r_map [MAX_ROWS];
    logic [AW-1:0] r_clr;

    // fill sweep: logical rows [r_fr, r_fre], in row r_fr columns from r_fc
    // to r_fce on first row, full width on later; last row ends at r_lce
    logic [RL-1:0] r_fr, r_fre;
    logic [CL-1:0] r_fc, r_fce, r_lce;
    logic [5:0]    r_rot;

    // clamped geometry, 32 bit to keep compares simple
    int unsigned w, h, m, row_i, col_i, cnt_i, hgt, fs, fe;
    int unsigned fsc, fce, lce;
    logic        empty;

    always_comb begin
        w = (i_cols == 8'd0) ? 1 : ((32'(i_cols) > MAX_COLS) ? MAX_COLS : 32'(i_cols));
        h = (i_rows == 6'd0) ? 1 : ((32'(i_rows) > MAX_ROWS) ? MAX_ROWS : 32'(i_rows));
        m = (32'(i_margin) > h - 1) ? h - 1 : 32'(i_margin);
        row_i = 32'(r_row);
        col_i = 32'(r_col);
        cnt_i = 32'(r_count);
        hgt = m - row_i + 1;
        fs = 0; fe = 0; fsc = 0; fce = w; lce = w; empty = 1'b1;
        unique case (r_op)
            tgse_pkg::OP_INIT: begin
                fs = 0; fe = h - 1; empty = 1'b0;
            end
            tgse_pkg::OP_SCROLL_UP, tgse_pkg::OP_SCROLL_DN: begin
                if (row_i <= m) begin
                    empty = 1'b0;
                    if (cnt_i >= hgt) begin
                        fs = row_i; fe = m;
                    end else if (r_op == tgse_pkg::OP_SCROLL_UP) begin
                        fs = m + 1 - cnt_i; fe = m;
                    end else begin
                        fs = row_i; fe = row_i + cnt_i - 1;
                    end
                end
            end
            tgse_pkg::OP_ERASE: begin
                case (r_mode)
                    tgse_pkg::ERASE_TO_END: begin
                        if (row_i < h) begin
                            fs = row_i; fe = h - 1; fsc = col_i;
                            fce = w; empty = 1'b0;
                        end else begin
                            empty = 1'b1;
                        end
                    end
                    tgse_pkg::ERASE_TO_CURS: begin
                        if (row_i < h) begin
                            fs = 0; fe = row_i;
                            lce = (col_i + 1 > w) ? w : col_i + 1;
                        end else begin
                            fs = 0; fe = h - 1;
                        end
                        empty = 1'b0;
                    end
                    tgse_pkg::ERASE_ALL: begin
                        fs = 0; fe = h - 1; empty = 1'b0;
                    end
                    default: empty = 1'b1;
                endcase
            end
            default: empty = 1'b1;
        endcase
        // first row column start beyond end row end: row cells empty
        if (fs == fe && fsc >= ((fe == fs) ? lce : fce)) begin
            empty = empty | (fsc >= lce);
        end
    end

    // sweep cell progress
    int unsigned cur_end;
    logic        row_done;
    always_comb begin
        cur_end  = (r_fr == r_fre) ? 32'(r_lce) : 32'(r_fce);
        row_done = (32'(r_fc) + 1 >= cur_end);
    end

    // a sweep row whose span is empty (first row starting past end) is skipped
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op <= i_opcode; r_row <= i_row; r_col <= i_col;
            r_count <= i_count; r_mode <= i_erase_mode;
            r_char <= i_char_code; r_attr <= i_attr_value;
        end
        if (i_cmd.fill_start) begin
            r_fr  <= RL'(fs);
            r_fre <= RL'(fe);
            r_fc  <= CL'(fsc);
            r_fce <= CL'(w);
            r_lce <= CL'(lce);
            r_rot <= (r_op == tgse_pkg::OP_SCROLL_UP) ? r_count : 6'(hgt - cnt_i);
        end else if (i_cmd.fill_step) begin
            if (row_done || 32'(r_fc) >= cur_end) begin
                r_fr <= r_fr + 1'b1;
                r_fc <= '0;
            end else begin
                r_fc <= r_fc + 1'b1;
            end
        end
        if (i_cmd.map_rot) begin
            r_rot <= r_rot - 1'b1;
        end
    end

    // reset pass: sweep every cell address once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    // rotate region [r_row, m] by one, iterated r_rot times
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.map_id) begin
            for (int i = 0; i < MAX_ROWS; i++) r_map[i] <= RW'(i);
        end else if (i_cmd.map_rot) begin
            for (int i = 0; i < MAX_ROWS; i++) begin
                if (i >= row_i && i <= m) begin
                    if (i == m) r_map[i] <= r_map[row_i];
                    else r_map[i] <= r_map[i+1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.attr_def) begin
            r_cur_attr <= i_defattr;
        end else if (i_cmd.attr_set) begin
            r_cur_attr <= r_attr;
        end
    end

    // a row whose column start is past its end writes nothing
    logic skip_cell;
    assign skip_cell = (32'(r_fc) >= cur_end) || (32'(r_fr) >= h);

    logic [RW-1:0] lrow, prow;
    logic [CW-1:0] acol;
    logic [AW-1:0] addr;
    logic          we;
    logic [15:0]   wdata;
    always_comb begin
        if (i_cmd.clr_step) begin
            lrow  = '0;
            acol  = '0;
            wdata = {tgse_pkg::RESET_ATTR, tgse_pkg::BLANK_CHAR};
            we    = 1'b1;
        end else if (i_cmd.fill_step) begin
            lrow  = r_fr[RW-1:0];
            acol  = r_fc[CW-1:0];
            wdata = {r_cur_attr, tgse_pkg::BLANK_CHAR};
            we    = !skip_cell;
        end else begin
            lrow  = RW'(r_row);
            acol  = CW'(r_col);
            wdata = {r_cur_attr, r_char};
            we    = i_cmd.cell_wr;
        end
        prow = r_map[lrow];
        addr = i_cmd.clr_step ? r_clr : {prow, acol};
    end

    tgse_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_addr (addr),
        .i_wdata(wdata),
        .o_rdata(o_rdata)
    );

    always_comb begin
        o_sts.on_screen  = (row_i < h) && (col_i < w);
        o_sts.fill_last  = (r_fr == r_fre) && (row_done || skip_cell);
        o_sts.fill_empty = empty;
        o_sts.rot_last   = (r_rot <= 6'd1);
        o_sts.scroll_ok  = (row_i <= m) && (r_count != 6'd0);
        o_sts.scroll_all = (cnt_i >= hgt);
        o_sts.clr_last   = (r_clr == AW'(DEPTH - 1));
    end
endmodule

@@ rtl/tgse_ctrl.sv @@
// ----------------------------------------------------------------------------
// tgse_ctrl
// Command sequencer: decode, rotate map, sweep blank cells, read, respond.
// ----------------------------------------------------------------------------
module tgse_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [2:0]     i_opcode,
    output tgse_pkg::t_cmd o_cmd,
    input  tgse_pkg::t_sts i_sts,
    input  logic [15:0]    i_rdata,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_cell_char,
    output logic [7:0]     o_cell_attr,
    output logic           o_is_read
);
    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_DECODE, S_ROT, S_PLAN, S_FILL, S_READ, S_RESP
    } t_state;
    t_state r_state, n_state;
    logic   r_valid;
    logic   r_rd;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_valid;

    always_comb begin
        o_cmd = '0;
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: if (i_valid && o_ready) begin
                o_cmd.latch = 1'b1;
                n_state = S_DECODE;
            end
            S_DECODE: begin
                n_state = S_RESP;
                case (i_opcode)
                    tgse_pkg::OP_INIT: begin
                        o_cmd.map_id = 1'b1; o_cmd.attr_def = 1'b1;
                        n_state = S_PLAN;
                    end
                    tgse_pkg::OP_SCROLL_UP, tgse_pkg::OP_SCROLL_DN: begin
                        o_cmd.fill_start = 1'b1;
                        if (i_sts.scroll_ok)
                            n_state = i_sts.scroll_all ? S_PLAN : S_ROT;
                    end
                    tgse_pkg::OP_ERASE: n_state = S_PLAN;
                    tgse_pkg::OP_WRITE: o_cmd.cell_wr = i_sts.on_screen;
                    tgse_pkg::OP_READ: if (i_sts.on_screen) n_state = S_READ;
                    tgse_pkg::OP_SET_ATTR: o_cmd.attr_set = 1'b1;
                    default: o_cmd.attr_def = 1'b1;
                endcase
            end
            S_ROT: begin
                o_cmd.map_rot = 1'b1;
                if (i_sts.rot_last) n_state = S_PLAN;
            end
            S_PLAN: begin
                o_cmd.fill_start = 1'b1;
                n_state = i_sts.fill_empty ? S_RESP : S_FILL;
            end
            S_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_sts.fill_last) n_state = S_RESP;
            end
            S_READ: n_state = S_RESP;
            // hold while the previous transaction still waits at the output
            S_RESP: n_state = (r_valid && !i_ready) ? S_RESP : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_valid <= 1'b0;
            r_rd    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_READ) r_rd <= 1'b1;
            if (r_state == S_RESP && n_state == S_IDLE) begin
                r_valid     <= 1'b1;
                o_is_read   <= r_rd;
                o_cell_char <= r_rd ? i_rdata[7:0] : 8'd0;
                o_cell_attr <= r_rd ? i_rdata[15:8] : 8'd0;
                r_rd        <= 1'b0;
            end else if (o_valid && i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end
endmodule

@@ rtl/text_grid_scroll_erase_engine.sv @@
// ----------------------------------------------------------------------------
// text_grid_scroll_erase_engine
// Character cell screen store with row map, scrolling and erase.
// ----------------------------------------------------------------------------
// One command at a time. After reset a clearing pass writes spaces in
// attribute 7 to all MAX_ROWS * MAX_COLS cells (4096 at the default size);
// the command input is not ready until it ends. Write, set attribute, reset
// attribute and a scroll that changes nothing go from decode straight to the
// response state, a read through a read state, an erase with nothing to
// blank through the planning state. Scroll first rotates the row map one row
// per cycle (count steps up, region minus count down) unless the count covers
// the region; init, scroll and erase then pass the planning state and blank
// one cell per cycle through the single cell store port. An erase to end
// that starts at or past the width on a row that is not the last also spends
// a sweep step on that row that writes nothing. A result waiting at the
// output does not block the next command; only a finished command holds in
// its response state until the previous result is taken.
module text_grid_scroll_erase_engine #(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [2:0] i_opcode,
    input  logic [4:0] i_row,
    input  logic [6:0] i_col,
    input  logic [5:0] i_count,
    input  logic [1:0] i_erase_mode,
    input  logic [7:0] i_char_code,
    input  logic [7:0] i_attr_value,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_cell_char,
    output logic [7:0] o_cell_attr,
    output logic       o_is_read,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);
    logic [7:0] r_cols, r_defattr;
    logic [5:0] r_rows;
    logic [4:0] r_margin;
    tgse_pkg::t_cmd cmd;
    tgse_pkg::t_sts sts;
    logic [15:0]    rdata;
    logic [2:0]     r_op;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= 8'd80; r_rows <= 6'd24; r_margin <= 5'd23;
            r_defattr <= tgse_pkg::RESET_ATTR;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tgse_pkg::CFG_COLS:   r_cols    <= i_cfg_data;
                tgse_pkg::CFG_ROWS:   r_rows    <= i_cfg_data[5:0];
                tgse_pkg::CFG_MARGIN: r_margin  <= i_cfg_data[4:0];
                default:              r_defattr <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.latch) r_op <= i_opcode;
    end

    tgse_datapath #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_sts(sts),
        .i_cols(r_cols), .i_rows(r_rows), .i_margin(r_margin), .i_defattr(r_defattr),
        .i_opcode, .i_row, .i_col, .i_count, .i_erase_mode, .i_char_code,
        .i_attr_value, .o_rdata(rdata)
    );

    tgse_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_opcode(r_op),
        .o_cmd(cmd), .i_sts(sts), .i_rdata(rdata),
        .o_valid, .i_ready, .o_cell_char, .o_cell_attr, .o_is_read
    );
endmodule

@@ rtl/tgse_checker.sv @@
// ----------------------------------------------------------------------------
// tgse_checker
// Port level checks of the screen engine.
// ----------------------------------------------------------------------------
module tgse_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_ready,
    input logic       i_valid,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_cell_char,
    input logic [7:0] o_cell_attr,
    input logic       o_is_read
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_cell_char))
        else $error("result dropped");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_read |-> o_cell_char == 8'd0 && o_cell_attr == 8'd0)
        else $error("non read result carries data");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("accepted while busy");
endmodule

bind text_grid_scroll_erase_engine tgse_checker u_chk (.*);
